// ===== rtl/pai_pkg.sv =====
// shared constants and types for the particle attractor integrator
`timescale 1ns / 1ps
`default_nettype none

package pai_pkg;

   localparam int FRAC_BITS_DEF   = 8;
   localparam int COORD_WIDTH_DEF = 24;
   localparam int MASS_W          = 16;
   localparam int DT_W            = 16;
   localparam int ATT_W           = 20;
   localparam int AREA_W          = 13;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 20;

   localparam logic [ATT_W-1:0]  ATT_X_RST  = ATT_W'(163840);
   localparam logic [ATT_W-1:0]  ATT_Y_RST  = ATT_W'(122880);
   localparam logic [AREA_W-1:0] AREA_W_RST = AREA_W'(1280);
   localparam logic [AREA_W-1:0] AREA_H_RST = AREA_W'(960);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ATTRACTOR_X = 2'd0,
      CSR_ATTRACTOR_Y = 2'd1,
      CSR_AREA_WIDTH  = 2'd2,
      CSR_AREA_HEIGHT = 2'd3
   } csr_index_type;

endpackage

`default_nettype wire

// ===== rtl/pai_front.sv =====
// distance vector, range scaling and squares ahead of the root
`timescale 1ns / 1ps
`default_nettype none

module pai_front import pai_pkg::*; #(
   parameter int CW     = COORD_WIDTH_DEF,
   parameter int DIFF_W = 26,
   parameter int MAG_W  = 25,
   parameter int RW     = 25,
   parameter int KW     = 5,
   parameter int SQ_W   = 51,
   parameter int SIDE_W = 128
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     en,
   input  wire                     in_valid,
   input  wire signed [CW-1:0]     pos_x,
   input  wire signed [CW-1:0]     pos_y,
   input  wire        [ATT_W-1:0]  att_x,
   input  wire        [ATT_W-1:0]  att_y,
   input  wire        [SIDE_W-1:0] side_in,
   output logic                    out_valid,
   output logic       [SQ_W-1:0]   sum,
   output logic       [KW-1:0]     k,
   output logic                    sign_x,
   output logic                    sign_y,
   output logic       [MAG_W-1:0]  mag_x,
   output logic       [MAG_W-1:0]  mag_y,
   output logic       [SIDE_W-1:0] side_out
);

   logic signed [DIFF_W-1:0] dx_in, dy_in;
   logic [MAG_W-1:0] mx_in, my_in, orm;
   logic [KW-1:0] k_in;
   logic [RW-1:0] a_in, b_in;

   logic v1_ff, v2_ff, v3_ff;
   logic s1x_ff, s1y_ff, s2x_ff, s2y_ff, s3x_ff, s3y_ff;
   logic [MAG_W-1:0] m1x_ff, m1y_ff, m2x_ff, m2y_ff, m3x_ff, m3y_ff;
   logic [SIDE_W-1:0] sd1_ff, sd2_ff, sd3_ff;
   logic [KW-1:0] k2_ff, k3_ff;
   logic [RW-1:0] a_ff, b_ff;
   logic [2*RW-1:0] sqa_ff, sqb_ff, sqa_in, sqb_in;

   assign dx_in = $signed({{(DIFF_W-ATT_W){1'b0}}, att_x}) - DIFF_W'(pos_x);
   assign dy_in = $signed({{(DIFF_W-ATT_W){1'b0}}, att_y}) - DIFF_W'(pos_y);
   assign mx_in = dx_in[DIFF_W-1] ? MAG_W'(-dx_in) : MAG_W'(dx_in);
   assign my_in = dy_in[DIFF_W-1] ? MAG_W'(-dy_in) : MAG_W'(dy_in);

   // bring both magnitudes below 2^31 before squaring
   always_comb begin
      orm  = m1x_ff | m1y_ff;
      k_in = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (i >= 31 && orm[i]) k_in = KW'(i - 30);
      end
      a_in = RW'(m1x_ff >> k_in);
      b_in = RW'(m1y_ff >> k_in);
   end

   assign sqa_in = (2*RW)'(a_ff) * (2*RW)'(a_ff);
   assign sqb_in = (2*RW)'(b_ff) * (2*RW)'(b_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1x_ff <= dx_in[DIFF_W-1];
         s1y_ff <= dy_in[DIFF_W-1];
         m1x_ff <= mx_in;
         m1y_ff <= my_in;
         sd1_ff <= side_in;
         s2x_ff <= s1x_ff;
         s2y_ff <= s1y_ff;
         m2x_ff <= m1x_ff;
         m2y_ff <= m1y_ff;
         sd2_ff <= sd1_ff;
         k2_ff  <= k_in;
         a_ff   <= a_in;
         b_ff   <= b_in;
         s3x_ff <= s2x_ff;
         s3y_ff <= s2y_ff;
         m3x_ff <= m2x_ff;
         m3y_ff <= m2y_ff;
         sd3_ff <= sd2_ff;
         k3_ff  <= k2_ff;
         sqa_ff <= sqa_in;
         sqb_ff <= sqb_in;
      end
   end

   assign out_valid = v3_ff;
   assign sum       = SQ_W'(sqa_ff) + SQ_W'(sqb_ff);
   assign k         = k3_ff;
   assign sign_x    = s3x_ff;
   assign sign_y    = s3y_ff;
   assign mag_x     = m3x_ff;
   assign mag_y     = m3y_ff;
   assign side_out  = sd3_ff;

endmodule

`default_nettype wire

// ===== rtl/pai_isqrt.sv =====
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
`default_nettype none

module pai_isqrt import pai_pkg::*; #(
   parameter int IN_W   = 51,
   parameter int SIDE_W = 8,
   parameter int RT_W   = (IN_W + 1) / 2
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     en,
   input  wire                     in_valid,
   input  wire        [IN_W-1:0]   radicand,
   input  wire        [SIDE_W-1:0] side_in,
   output logic                    out_valid,
   output logic       [RT_W-1:0]   root,
   output logic       [SIDE_W-1:0] side_out
);

   localparam int PAD = 2 * RT_W;

   logic [RT_W+1:0]   rem_ff  [RT_W];
   logic [RT_W-1:0]   root_ff [RT_W];
   logic [PAD-1:0]    n_ff    [RT_W];
   logic [SIDE_W-1:0] side_ff [RT_W];
   logic              vld_ff  [RT_W];

   for (genvar s = 0; s < RT_W; s++) begin : g_st
      logic [RT_W+1:0]   rem_p, rem_t, trial;
      logic [RT_W-1:0]   root_p;
      logic [PAD-1:0]    n_p;
      logic [SIDE_W-1:0] side_p;
      logic              vld_p, ge;

      if (s == 0) begin : g_first
         assign rem_p  = '0;
         assign root_p = '0;
         assign n_p    = PAD'(radicand);
         assign side_p = side_in;
         assign vld_p  = in_valid;
      end else begin : g_next
         assign rem_p  = rem_ff[s-1];
         assign root_p = root_ff[s-1];
         assign n_p    = n_ff[s-1];
         assign side_p = side_ff[s-1];
         assign vld_p  = vld_ff[s-1];
      end

      assign rem_t = {rem_p[RT_W-1:0], n_p[PAD-1 -: 2]};
      assign trial = {root_p, 2'b01};
      assign ge    = rem_t >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= ge ? rem_t - trial : rem_t;
            root_ff[s] <= {root_p[RT_W-2:0], ge};
            n_ff[s]    <= n_p << 2;
            side_ff[s] <= side_p;
         end
      end
   end

   assign out_valid = vld_ff[RT_W-1];
   assign root      = root_ff[RT_W-1];
   assign side_out  = side_ff[RT_W-1];

endmodule

`default_nettype wire

// ===== rtl/pai_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none

module pai_div import pai_pkg::*; #(
   parameter int NW     = 33,
   parameter int DW     = 26,
   parameter int QW     = 10,
   parameter int SIDE_W = 8
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     en,
   input  wire                     in_valid,
   input  wire        [NW-1:0]     num,
   input  wire        [DW-1:0]     den,
   input  wire        [SIDE_W-1:0] side_in,
   output logic                    out_valid,
   output logic       [QW-1:0]     quot,
   output logic       [SIDE_W-1:0] side_out
);

   localparam int CMP_W = (NW > DW + QW) ? NW : DW + QW;

   logic [NW-1:0]     rem_ff  [QW];
   logic [DW-1:0]     den_ff  [QW];
   logic [QW-1:0]     q_ff    [QW];
   logic [SIDE_W-1:0] side_ff [QW];
   logic              vld_ff  [QW];

   for (genvar s = 0; s < QW; s++) begin : g_st
      logic [NW-1:0]     rem_p;
      logic [DW-1:0]     den_p;
      logic [QW-1:0]     q_p;
      logic [SIDE_W-1:0] side_p;
      logic              vld_p, ge;
      logic [CMP_W-1:0]  den_sh, rem_c;

      if (s == 0) begin : g_first
         assign rem_p  = num;
         assign den_p  = den;
         assign q_p    = '0;
         assign side_p = side_in;
         assign vld_p  = in_valid;
      end else begin : g_next
         assign rem_p  = rem_ff[s-1];
         assign den_p  = den_ff[s-1];
         assign q_p    = q_ff[s-1];
         assign side_p = side_ff[s-1];
         assign vld_p  = vld_ff[s-1];
      end

      assign den_sh = CMP_W'(den_p) << (QW - 1 - s);
      assign rem_c  = CMP_W'(rem_p);
      assign ge     = rem_c >= den_sh;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= ge ? NW'(rem_c - den_sh) : rem_p;
            den_ff[s]  <= den_p;
            q_ff[s]    <= {q_p[QW-2:0], ge};
            side_ff[s] <= side_p;
         end
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign quot      = q_ff[QW-1];
   assign side_out  = side_ff[QW-1];

endmodule

`default_nettype wire

// ===== rtl/pai_axis.sv =====
// per-axis euler update, saturation and boundary bounce
`timescale 1ns / 1ps
`default_nettype none

module pai_axis import pai_pkg::*; #(
   parameter int CW    = COORD_WIDTH_DEF,
   parameter int F     = FRAC_BITS_DEF,
   parameter int ACC_W = 19
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     en,
   input  wire                     in_valid,
   input  wire signed [CW-1:0]     pos,
   input  wire signed [CW-1:0]     vel,
   input  wire signed [ACC_W-1:0]  acc,
   input  wire        [DT_W-1:0]   dt,
   input  wire        [AREA_W-1:0] area,
   output logic                    out_valid,
   output logic signed [CW-1:0]    new_pos,
   output logic signed [CW-1:0]    new_vel,
   output logic                    bounced
);

   localparam int P1_W = DT_W + 1 + ACC_W;
   localparam int VR_W = ((CW > P1_W - F) ? CW : P1_W - F) + 1;
   localparam int H_W  = P1_W - F - 1;
   localparam int S_W  = ((CW > H_W) ? CW : H_W) + 1;
   localparam int P2_W = DT_W + 1 + S_W;
   localparam int PR_W = ((CW > P2_W - F) ? CW : P2_W - F) + 1;
   localparam int BW   = ((CW > AREA_W + F + 1) ? CW : AREA_W + F + 1) + 1;
   localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

   logic va_ff, vb_ff, vc_ff, vd_ff, ve_ff;
   logic signed [P1_W-1:0] p1_ff;
   logic signed [CW-1:0] pa_ff, pb_ff, pc_ff, pd_ff, pe_ff;
   logic signed [CW-1:0] va_d_ff, vb_d_ff, vc_d_ff, vd_d_ff, ve_d_ff;
   logic [DT_W-1:0] dta_ff, dtb_ff;
   logic signed [H_W-1:0] hb_ff;
   logic signed [P2_W-1:0] p2_ff;
   logic be_ff;

   logic signed [VR_W-1:0] vr;
   logic signed [CW-1:0]   vsat;
   logic signed [S_W-1:0]  ssum;
   logic signed [PR_W-1:0] pr;
   logic signed [CW-1:0]   psat;
   logic signed [BW-1:0]   pext, lim;
   logic                   bnc;
   logic signed [CW-1:0]   vneg;

   always_comb begin
      vr = VR_W'(va_d_ff) + VR_W'(p1_ff >>> F);
      if (vr > VR_W'(CMAX)) vsat = CMAX;
      else if (vr < VR_W'(CMIN)) vsat = CMIN;
      else vsat = CW'(vr);
      ssum = S_W'(vb_d_ff) + S_W'(hb_ff);
      pr = PR_W'(pc_ff) + PR_W'(p2_ff >>> F);
      if (pr > PR_W'(CMAX)) psat = CMAX;
      else if (pr < PR_W'(CMIN)) psat = CMIN;
      else psat = CW'(pr);
      pext = BW'(pd_ff);
      lim  = $signed(BW'({area, {F{1'b0}}}));
      bnc  = pd_ff[CW-1] || (pext > lim);
      vneg = (vd_d_ff == CMIN) ? CMAX : -vd_d_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
         ve_ff <= vd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff   <= $signed({1'b0, dt}) * acc;
         pa_ff   <= pos;
         va_d_ff <= vel;
         dta_ff  <= dt;
         pb_ff   <= pa_ff;
         vb_d_ff <= vsat;
         dtb_ff  <= dta_ff;
         hb_ff   <= H_W'(p1_ff >>> (F + 1));
         pc_ff   <= pb_ff;
         vc_d_ff <= vb_d_ff;
         p2_ff   <= $signed({1'b0, dtb_ff}) * ssum;
         pd_ff   <= psat;
         vd_d_ff <= vc_d_ff;
         pe_ff   <= pd_ff;
         ve_d_ff <= bnc ? vneg : vd_d_ff;
         be_ff   <= bnc;
      end
   end

   assign out_valid = ve_ff;
   assign new_pos   = pe_ff;
   assign new_vel   = ve_d_ff;
   assign bounced   = be_ff;

endmodule

`default_nettype wire

// ===== rtl/particle_attractor_integrator_top.sv =====
// pipeline: front end, square root, unit-vector dividers, acceleration dividers, then axis integration
// throughput: one item per cycle; every stage of the root and all four dividers is its own
// register stage, and the whole pipeline holds while the output item waits
// reset: synchronous, active high; clears the valid bits and loads the attractor
// and area registers with their defaults
`timescale 1ns / 1ps
`default_nettype none

module particle_attractor_integrator_top import pai_pkg::*; #(
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int IN_W  = ((4 * COORD_WIDTH + MASS_W + DT_W + 7) / 8) * 8,
   parameter int OUT_W = ((4 * COORD_WIDTH + 7) / 8) * 8
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   // pos_x, pos_y, vel_x, vel_y, mass, time_step
   input  wire  [IN_W-1:0]       req_tdata,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   // new_pos_x, new_pos_y, new_vel_x, new_vel_y
   output logic [OUT_W-1:0]      rsp_tdata,
   // bounced_x, bounced_y
   output logic [1:0]            rsp_tuser,
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire  [CSR_IDX_W-1:0]  csr_index,
   input  wire  [CSR_DATA_W-1:0] csr_data
);

   localparam int CW     = COORD_WIDTH;
   localparam int F      = FRAC_BITS;
   localparam int DIFF_W = ((CW > ATT_W) ? CW : ATT_W) + 2;
   localparam int MAG_W  = DIFF_W - 1;
   localparam int RW     = (MAG_W < 31) ? MAG_W : 31;
   localparam int KW     = $clog2(MAG_W);
   localparam int SQ_W   = 2 * RW + 1;
   localparam int RT_W   = (SQ_W + 1) / 2;
   localparam int LEN_W  = RT_W + MAG_W - RW;
   localparam int QU_W   = F + 2;
   localparam int Q2_W   = QU_W + F;
   localparam int ACC_W  = Q2_W + 1;
   localparam int SB0    = 4 * CW + MASS_W + DT_W;
   localparam int SB1    = SB0 + 2 + 2 * MAG_W + KW;
   localparam int SB2    = SB0 + 2;

   logic [ATT_W-1:0]  att_x_ff, att_y_ff;
   logic [AREA_W-1:0] area_w_ff, area_h_ff;
   logic en;

   logic signed [CW-1:0] in_px, in_py, in_vx, in_vy;
   logic [MASS_W-1:0] in_mass;
   logic [DT_W-1:0]   in_dt;

   assign in_px   = req_tdata[CW-1:0];
   assign in_py   = req_tdata[2*CW-1:CW];
   assign in_vx   = req_tdata[3*CW-1:2*CW];
   assign in_vy   = req_tdata[4*CW-1:3*CW];
   assign in_mass = req_tdata[4*CW+MASS_W-1:4*CW];
   assign in_dt   = req_tdata[4*CW+MASS_W+DT_W-1:4*CW+MASS_W];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         att_x_ff  <= ATT_X_RST;
         att_y_ff  <= ATT_Y_RST;
         area_w_ff <= AREA_W_RST;
         area_h_ff <= AREA_H_RST;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_ATTRACTOR_X: begin
               att_x_ff <= csr_data[ATT_W-1:0];
            end
            CSR_ATTRACTOR_Y: begin
               att_y_ff <= csr_data[ATT_W-1:0];
            end
            CSR_AREA_WIDTH: begin
               area_w_ff <= csr_data[AREA_W-1:0];
            end
            CSR_AREA_HEIGHT: begin
               area_h_ff <= csr_data[AREA_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // front end
   logic f_vld, f_sx, f_sy;
   logic [SQ_W-1:0] f_sum;
   logic [KW-1:0] f_k;
   logic [MAG_W-1:0] f_mx, f_my;
   logic [SB0-1:0] f_side;

   pai_front #(
      .CW(CW), .DIFF_W(DIFF_W), .MAG_W(MAG_W), .RW(RW), .KW(KW),
      .SQ_W(SQ_W), .SIDE_W(SB0)
   ) u_front (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_tvalid),
      .pos_x(in_px), .pos_y(in_py), .att_x(att_x_ff), .att_y(att_y_ff),
      .side_in(req_tdata[SB0-1:0]),
      .out_valid(f_vld), .sum(f_sum), .k(f_k), .sign_x(f_sx), .sign_y(f_sy),
      .mag_x(f_mx), .mag_y(f_my), .side_out(f_side)
   );

   // square root
   logic r_vld, r_sx, r_sy;
   logic [RT_W-1:0] r_root;
   logic [KW-1:0] r_k;
   logic [MAG_W-1:0] r_mx, r_my;
   logic [SB0-1:0] r_side;
   logic [LEN_W-1:0] r_len;
   logic r_zero;

   pai_isqrt #(.IN_W(SQ_W), .SIDE_W(SB1), .RT_W(RT_W)) u_isqrt (
      .clock(clock), .reset(reset), .en(en), .in_valid(f_vld), .radicand(f_sum),
      .side_in({f_side, f_sx, f_sy, f_mx, f_my, f_k}),
      .out_valid(r_vld), .root(r_root),
      .side_out({r_side, r_sx, r_sy, r_mx, r_my, r_k})
   );

   assign r_len  = LEN_W'(r_root) << r_k;
   assign r_zero = (r_root == '0);

   // unit vector
   logic u_vld, u_vld_y, u_sx, u_sy, u_zero;
   logic [QU_W-1:0] u_qx, u_qy;
   logic [SB0-1:0] u_side;

   pai_div #(.NW(MAG_W + F), .DW(LEN_W), .QW(QU_W), .SIDE_W(SB2)) u_unit_x (
      .clock(clock), .reset(reset), .en(en), .in_valid(r_vld),
      .num({r_mx, {F{1'b0}}}), .den(r_len), .side_in({r_side, r_sx, r_zero}),
      .out_valid(u_vld), .quot(u_qx), .side_out({u_side, u_sx, u_zero})
   );

   pai_div #(.NW(MAG_W + F), .DW(LEN_W), .QW(QU_W), .SIDE_W(1)) u_unit_y (
      .clock(clock), .reset(reset), .en(en), .in_valid(r_vld),
      .num({r_my, {F{1'b0}}}), .den(r_len), .side_in(r_sy),
      .out_valid(u_vld_y), .quot(u_qy), .side_out(u_sy)
   );

   // acceleration
   logic [MASS_W-1:0] u_mass;
   logic a_vld, a_vld_y, a_sx, a_sy, a_zero;
   logic [Q2_W-1:0] a_qx, a_qy;
   logic [SB0-1:0] a_side;
   logic signed [ACC_W-1:0] acc_x, acc_y;
   logic signed [CW-1:0] a_px, a_py, a_vx, a_vy;
   logic [MASS_W-1:0] a_mass;
   logic [DT_W-1:0] a_dt;

   assign u_mass = u_side[4*CW+MASS_W-1:4*CW];

   pai_div #(.NW(Q2_W), .DW(MASS_W), .QW(Q2_W), .SIDE_W(SB2)) u_acc_x (
      .clock(clock), .reset(reset), .en(en), .in_valid(u_vld),
      .num({u_qx, {F{1'b0}}}), .den(u_mass),
      .side_in({u_side, u_sx, u_zero || (u_mass == '0)}),
      .out_valid(a_vld), .quot(a_qx), .side_out({a_side, a_sx, a_zero})
   );

   pai_div #(.NW(Q2_W), .DW(MASS_W), .QW(Q2_W), .SIDE_W(1)) u_acc_y (
      .clock(clock), .reset(reset), .en(en), .in_valid(u_vld_y),
      .num({u_qy, {F{1'b0}}}), .den(u_mass), .side_in(u_sy),
      .out_valid(a_vld_y), .quot(a_qy), .side_out(a_sy)
   );

   assign {a_dt, a_mass, a_vy, a_vx, a_py, a_px} = a_side;
   assign acc_x = a_zero ? '0 : (a_sx ? -$signed(ACC_W'(a_qx)) : $signed(ACC_W'(a_qx)));
   assign acc_y = a_zero ? '0 : (a_sy ? -$signed(ACC_W'(a_qy)) : $signed(ACC_W'(a_qy)));

   // integration
   logic o_vld_y, o_bx, o_by;
   logic signed [CW-1:0] o_px, o_py, o_vx, o_vy;

   pai_axis #(.CW(CW), .F(F), .ACC_W(ACC_W)) u_axis_x (
      .clock(clock), .reset(reset), .en(en), .in_valid(a_vld),
      .pos(a_px), .vel(a_vx), .acc(acc_x), .dt(a_dt), .area(area_w_ff),
      .out_valid(rsp_tvalid), .new_pos(o_px), .new_vel(o_vx), .bounced(o_bx)
   );

   pai_axis #(.CW(CW), .F(F), .ACC_W(ACC_W)) u_axis_y (
      .clock(clock), .reset(reset), .en(en), .in_valid(a_vld_y),
      .pos(a_py), .vel(a_vy), .acc(acc_y), .dt(a_dt), .area(area_h_ff),
      .out_valid(o_vld_y), .new_pos(o_py), .new_vel(o_vy), .bounced(o_by)
   );

   assign rsp_tdata = OUT_W'({o_vy, o_vx, o_py, o_px});
   assign rsp_tuser = {o_by, o_bx};

   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      o_vld_y == rsp_tvalid && a_vld_y == a_vld && u_vld_y == u_vld)
      else $error("x and y lanes out of step");

   a_stall_only_on_output: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input held without a waiting output item");

   a_no_bounce_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && o_px[CW-1] |-> o_bx)
      else $error("negative x position without bounce");

   a_zero_accel: assert property (@(posedge clock) disable iff (reset)
      a_vld && a_zero |-> acc_x == '0 && acc_y == '0)
      else $error("acceleration not zero at zero distance");

endmodule

`default_nettype wire

// ===== test/particle_attractor_integrator_top_tb.sv =====
// testbench for the particle attractor integrator: directed and random particles checked
`timescale 1ns / 1ps

module particle_attractor_integrator_top_tb;
   import pai_pkg::*;

   localparam int FB = 8;
   localparam int CW = 24;
   localparam int LIMIT = 400000;
   localparam longint SAT_HI = (64'sd1 <<< (CW - 1)) - 1;
   localparam longint SAT_LO = -SAT_HI - 1;

   typedef struct {
      logic signed [CW-1:0] px, py, vx, vy;
      logic bx, by;
   } motion_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [127:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [95:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   logic [ATT_W-1:0] att_x, att_y;
   logic [AREA_W-1:0] area_w, area_h;
   motion_type motion_q[$];
   int errors = 0;
   int cycles = 0;
   int hold_cycles = 0;
   bit quiet = 0;

   particle_attractor_integrator_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic longint sat(longint x);
      if (x > SAT_HI) return SAT_HI;
      if (x < SAT_LO) return SAT_LO;
      return x;
   endfunction

   function automatic longint unsigned root(longint unsigned n);
      longint unsigned r = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic void move_axis(input longint p, input longint v, input longint acc,
                                     input longint dt, input longint lim,
                                     output longint pn, output longint vn, output logic bn);
      longint half;
      vn = sat(v + ((dt * acc) >>> FB));
      half = (dt * acc) >>> (FB + 1);
      pn = sat(p + ((dt * (vn + half)) >>> FB));
      bn = (pn < 0) || (pn > lim);
      if (bn) vn = sat(-vn);
   endfunction

   function automatic motion_type advance(logic [127:0] d);
      motion_type m;
      longint px, py, vx, vy, mass, dt, dx, dy, ax, ay, pn, vn;
      longint unsigned len;
      logic bn;
      px = longint'($signed(d[23:0]));
      py = longint'($signed(d[47:24]));
      vx = longint'($signed(d[71:48]));
      vy = longint'($signed(d[95:72]));
      mass = longint'(d[111:96]);
      dt = longint'(d[127:112]);
      dx = longint'(att_x) - px;
      dy = longint'(att_y) - py;
      ax = 0;
      ay = 0;
      len = root(longint'(dx * dx + dy * dy));
      if (len != 0 && mass != 0) begin
         ax = (((dx <<< FB) / longint'(len)) <<< FB) / mass;
         ay = (((dy <<< FB) / longint'(len)) <<< FB) / mass;
      end
      move_axis(px, vx, ax, dt, longint'(area_w) <<< FB, pn, vn, bn);
      m.px = pn[CW-1:0];
      m.vx = vn[CW-1:0];
      m.bx = bn;
      move_axis(py, vy, ay, dt, longint'(area_h) <<< FB, pn, vn, bn);
      m.py = pn[CW-1:0];
      m.vy = vn[CW-1:0];
      m.by = bn;
      return m;
   endfunction

   task automatic report(input string what, input logic [CW-1:0] got, input logic [CW-1:0] want);
      errors++;
      $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
   endtask

   always @(posedge clock) begin
      motion_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (motion_q.size() == 0) begin
            report("unexpected item", rsp_tdata[23:0], '0);
         end else begin
            w = motion_q.pop_front();
            if (rsp_tdata[23:0] !== w.px) report("new_pos_x", rsp_tdata[23:0], w.px);
            if (rsp_tdata[47:24] !== w.py) report("new_pos_y", rsp_tdata[47:24], w.py);
            if (rsp_tdata[71:48] !== w.vx) report("new_vel_x", rsp_tdata[71:48], w.vx);
            if (rsp_tdata[95:72] !== w.vy) report("new_vel_y", rsp_tdata[95:72], w.vy);
            if (rsp_tuser[0] !== w.bx)
               report("bounced_x", CW'(rsp_tuser[0]), CW'(w.bx));
            if (rsp_tuser[1] !== w.by)
               report("bounced_y", CW'(rsp_tuser[1]), CW'(w.by));
         end
      end
   end

   // receiver stalls: long hold on request, always ready when quiet, else random bursts
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 0;
         hold_cycles <= hold_cycles - 1;
      end else if (quiet) begin
         rsp_tready <= 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_tready <= 0;
         hold_cycles <= $urandom_range(0, 6);
      end else begin
         rsp_tready <= 1;
      end
   end

   task automatic send_item(input logic signed [CW-1:0] px, py, vx, vy,
                            input logic [15:0] mass, dt);
      int gap;
      gap = (quiet || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
         @(negedge clock) req_tvalid <= 0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1;
      req_tdata <= {dt, mass, vy, vx, py, px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      motion_q.push_back(advance(req_tdata));
   endtask

   task automatic settle();
      @(negedge clock) req_tvalid <= 0;
      while (motion_q.size() != 0) @(posedge clock);
      repeat (70) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_ATTRACTOR_X: att_x = val;
         CSR_ATTRACTOR_Y: att_y = val;
         CSR_AREA_WIDTH:  area_w = val[AREA_W-1:0];
         CSR_AREA_HEIGHT: area_h = val[AREA_W-1:0];
         default: ;
      endcase
      @(negedge clock) csr_valid <= 0;
   endtask

   task automatic set_scene(input logic [19:0] ax, ay, w, h);
      write_reg(CSR_ATTRACTOR_X, ax);
      write_reg(CSR_ATTRACTOR_Y, ay);
      write_reg(CSR_AREA_WIDTH, w);
      write_reg(CSR_AREA_HEIGHT, h);
   endtask

   task automatic send_random(input bit wide);
      logic signed [CW-1:0] px, py, vx, vy;
      logic [15:0] mass;
      if (wide) begin
         px = CW'($urandom);
         py = CW'($urandom);
         vx = CW'($urandom);
         vy = CW'($urandom);
         mass = 16'($urandom_range(1, 65535));
      end else begin
         px = CW'($urandom_range(0, 3000 * 256) - 500 * 256);
         py = CW'($urandom_range(0, 3000 * 256) - 500 * 256);
         vx = CW'($urandom_range(0, 8192) - 4096);
         vy = CW'($urandom_range(0, 8192) - 4096);
         mass = 16'(($urandom_range(0, 1) != 0) ? $urandom_range(1, 1024)
                                                 : $urandom_range(1, 65535));
      end
      send_item(px, py, vx, vy, mass, 16'($urandom));
   endtask

   task automatic test_directed();
      send_item(CW'(att_x), CW'(att_y), 24'sd1000, -24'sd1000, 16'd256, 16'd256);
      send_item(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 16'd1, 16'hFFFF);
      send_item(24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000, 16'd1, 16'hFFFF);
      send_item(-24'sd256, -24'sd256, 24'sh800000, 24'sh800000, 16'hFFFF, 16'd0);
      send_item(24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'd0, 16'd512);
      send_item(24'sd1, 24'sd1, -24'sd1, -24'sd1, 16'hFFFF, 16'd1);
      send_item(24'sd327680, 24'sd245760, 24'sd0, 24'sd0, 16'd256, 16'd256);
      send_item(24'sd327681, 24'sd245761, 24'sd50, -24'sd50, 16'd1, 16'd256);
      send_item(CW'(att_x) + 24'sd1, CW'(att_y), 24'sd0, 24'sd0, 16'd1, 16'hFFFF);
      send_item(CW'(att_x), CW'(att_y) - 24'sd1, 24'sd0, 24'sd0, 16'd1, 16'hFFFF);
      send_item(24'sd100, 24'sd100, -24'sd30000, 24'sd30000, 16'd300, 16'd2560);
      settle();
   endtask

   task automatic test_scenes();
      set_scene(20'd0, 20'd0, 20'd1, 20'd1);
      repeat (15) send_random(0);
      settle();
      set_scene(20'hFFFFF, 20'hFFFFF, 20'd4096, 20'd4096);
      repeat (15) send_random(0);
      repeat (5) send_random(1);
      settle();
      set_scene(20'd12345, 20'd999999, 20'd0, 20'd8191);
      repeat (15) send_random(0);
      settle();
      set_scene(ATT_X_RST, ATT_Y_RST, 20'(AREA_W_RST), 20'(AREA_H_RST));
   endtask

   task automatic test_random();
      repeat (4) begin
         set_scene(20'($urandom_range(0, 20'hFFFFF)), 20'($urandom_range(0, 20'hFFFFF)),
                   20'($urandom_range(1, 4096)), 20'($urandom_range(1, 4096)));
         repeat (50) send_random($urandom_range(0, 4) == 0);
         settle();
      end
   endtask

   task automatic test_backpressure();
      hold_cycles = 300;
      repeat (100) send_random(0);
      settle();
   endtask

   task automatic test_steady_stream();
      quiet = 1;
      repeat (60) send_random($urandom_range(0, 4) == 0);
      @(negedge clock) req_tvalid <= 0;
   endtask

   initial begin
      att_x = ATT_X_RST;
      att_y = ATT_Y_RST;
      area_w = AREA_W_RST;
      area_h = AREA_H_RST;
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 0;
      test_directed();
      test_scenes();
      test_backpressure();
      test_random();
      test_steady_stream();
      while (motion_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/pai_pkg.sv
rtl/pai_front.sv
rtl/pai_isqrt.sv
rtl/pai_div.sv
rtl/pai_axis.sv
rtl/particle_attractor_integrator_top.sv
test/particle_attractor_integrator_top_tb.sv
